[src/ilp_pkg.sv]
package ilp_pkg;

  localparam int unsigned ILP_QUEUE_DEPTH = 2;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UC_F  = 8'h46;
  localparam logic [CH_W-1:0] CH_LC_B  = 8'h62;
  localparam logic [CH_W-1:0] CH_LC_O  = 8'h6F;
  localparam logic [CH_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;

  // radix codes
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  // request kinds passed from front to back
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_DIGIT = 2'd1;
  localparam logic [1:0] OP_FAIL  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         radix;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } ilp_op_t;

endpackage

[src/ilp_front.sv]
module ilp_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             ch,
  input  logic                   last,
  output ilp_pkg::ilp_op_t       op
);
  import ilp_pkg::*;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_HEAD   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;

  logic [2:0] phase_r, phase_nxt;
  logic [1:0] radix_r, radix_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic               dig_ok;
  logic [DIGIT_W-1:0] dig_val;
  logic               below_base;
  ilp_op_t            scan_op;
  logic               is_prefix;

  // digit value of the character
  always_comb begin
    dig_ok  = 1'b1;
    dig_val = '0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      dig_val = DIGIT_W'(ch - CH_ZERO);
    end else if (ch >= CH_LC_A && ch <= CH_LC_F) begin
      dig_val = DIGIT_W'(ch - CH_LC_A + 8'd10);
    end else if (ch >= CH_UC_A && ch <= CH_UC_F) begin
      dig_val = DIGIT_W'(ch - CH_UC_A + 8'd10);
    end else begin
      dig_ok = 1'b0;
    end
  end

  always_comb begin
    case (radix_r)
      RADIX_BIN: below_base = (dig_val < 4'd2);
      RADIX_OCT: below_base = (dig_val < 4'd8);
      RADIX_HEX: below_base = 1'b1;
      default:   below_base = (dig_val < 4'd10);
    endcase
  end

  always_comb begin
    scan_op.radix = radix_r;
    scan_op.digit = dig_val;
    scan_op.last  = last;
    if (ch == CH_UNDER) begin
      scan_op.kind = OP_NOP;
    end else if (dig_ok && below_base) begin
      scan_op.kind = OP_DIGIT;
    end else begin
      scan_op.kind = OP_FAIL;
    end
  end

  assign is_prefix = (ch == CH_LC_B || ch == CH_LC_O || ch == CH_LC_X)
                     && (!last || cnt_r >= 2'd2);

  always_comb begin
    op        = scan_op;
    op.kind   = OP_NOP;
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    case (phase_r)
      PH_START, PH_HEAD: begin
        if (phase_r == PH_START && ch == CH_PLUS && !last) begin
          phase_nxt = PH_HEAD;
        end else if (ch == CH_ZERO) begin
          // leading zero may open a prefix; adds nothing to the value
          phase_nxt = PH_ZERO;
        end else begin
          phase_nxt = PH_DIGITS;
          op        = scan_op;
        end
      end
      PH_ZERO: begin
        phase_nxt = PH_DIGITS;
        if (is_prefix) begin
          radix_nxt = (ch == CH_LC_B) ? RADIX_BIN :
                      (ch == CH_LC_O) ? RADIX_OCT : RADIX_HEX;
        end else begin
          op = scan_op;
        end
      end
      default: begin
        op = scan_op;
      end
    endcase
    cnt_nxt = (cnt_r == 2'd3) ? cnt_r : cnt_r + 2'd1;
    if (last) begin
      phase_nxt = PH_START;
      radix_nxt = RADIX_DEC;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      radix_r <= RADIX_DEC;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[src/ilp_queue.sv]
module ilp_queue #(
  parameter int unsigned DEPTH = ilp_pkg::ILP_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  ilp_pkg::ilp_op_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output ilp_pkg::ilp_op_t rd_data,
  output logic             rd_valid
);
  import ilp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ilp_op_t            slot_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, rptr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[rptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
    end
  end

endmodule

[src/ilp_back.sv]
module ilp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_valid,
  input  ilp_pkg::ilp_op_t op,
  output logic             op_take,
  output logic [63:0]      value,
  output logic             ok,
  output logic             empty,
  input  logic             pop
);
  import ilp_pkg::*;

  logic [VALUE_W-1:0] accum_r, accum_nxt;
  logic               failed_r, failed_nxt;
  logic [VALUE_W-1:0] scaled;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_ok_r;
  logic               out_valid_r;

  // a final request waits only while the result register is held
  assign op_take = op_valid && (!op.last || !out_valid_r || pop);

  always_comb begin
    case (op.radix)
      RADIX_BIN: scaled = accum_r << 1;
      RADIX_OCT: scaled = accum_r << 3;
      RADIX_HEX: scaled = accum_r << 4;
      default:   scaled = (accum_r << 3) + (accum_r << 1);
    endcase
  end

  always_comb begin
    accum_nxt  = accum_r;
    failed_nxt = failed_r;
    if (!failed_r) begin
      case (op.kind)
        OP_DIGIT: accum_nxt  = scaled + VALUE_W'(op.digit);
        OP_FAIL:  failed_nxt = 1'b1;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (op_take) begin
        if (op.last) begin
          accum_r  <= '0;
          failed_r <= 1'b0;
        end else begin
          accum_r  <= accum_nxt;
          failed_r <= failed_nxt;
        end
      end
      if (op_take && op.last) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && op.last) begin
      out_value_r <= accum_nxt;
      out_ok_r    <= !failed_nxt;
    end
  end

  assign value = out_value_r;
  assign ok    = out_ok_r;
  assign empty = !out_valid_r;

endmodule

[src/integer_literal_parser.sv]
// Integer literal parser.
// Input queue side: one ASCII character per request on in_ch, with in_last
// set on the final character of a literal. A request is taken on a clock edge
// with in_push high and in_full low.
// Result queue side: one result per literal (out_value, out_ok), present
// while out_empty is low and taken on an edge with out_pop high.
// Accepts an optional '+', a 0b/0o/0x prefix, underscores, and hex digits in
// either case; value wraps modulo 2^64 and is partial when out_ok is low.
// Throughput: one character per cycle while in_full is low. The result of a
// literal is registered on its way to the ports: the request sits in the
// front/back queue, and the back then loads its result register when it
// takes that request.
// When the result is not popped, a further final character waits in the
// queue; once the queue fills, in_full rises until out_pop frees the slot.
// Reset (rst_n low, synchronous) clears the parse state, the queue and the
// result valid flag; out_empty is high and in_full low after reset.
module integer_literal_parser #(
  parameter int unsigned QUEUE_DEPTH = ilp_pkg::ILP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  input  logic        in_push,
  output logic        in_full,
  output logic [63:0] out_value,
  output logic        out_ok,
  output logic        out_empty,
  input  logic        out_pop
);
  import ilp_pkg::*;

  ilp_op_t front_op;
  ilp_op_t head_op;
  logic    accept;
  logic    head_valid;
  logic    head_take;

  assign accept = in_push && !in_full;

  ilp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .ch     (in_ch),
    .last   (in_last),
    .op     (front_op)
  );

  ilp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_push),
    .wr_data  (front_op),
    .full     (in_full),
    .rd_en    (head_take),
    .rd_data  (head_op),
    .rd_valid (head_valid)
  );

  ilp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (head_valid),
    .op       (head_op),
    .op_take  (head_take),
    .value    (out_value),
    .ok       (out_ok),
    .empty    (out_empty),
    .pop      (out_pop)
  );

endmodule

[src/ilp_checker.sv]
module ilp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic [63:0] out_value,
  input logic        out_ok,
  input logic        out_empty,
  input logic        out_pop
);

  // reset leaves both sides open
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not clear after reset");

  // input backs up only behind an unread result
  a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full with no result pending");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_value) && $stable(out_ok)))
    else $error("pending result changed before pop");

  // a stalled receiver with a full queue keeps the input blocked
  a_full_persists: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !out_pop) |=> in_full)
    else $error("input full dropped without a pop");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_value (out_value),
  .out_ok    (out_ok),
  .out_empty (out_empty),
  .out_pop   (out_pop)
);

[test/tb_integer_literal_parser.sv]
module tb_integer_literal_parser;
  import ilp_pkg::*;

  typedef logic [7:0] char_q_t[$];

  class literal_scoreboard;
    typedef enum logic [1:0] {AT_START, AFTER_SIGN, AFTER_ZERO, IN_DIGITS} scan_phase_t;

    scan_phase_t phase;
    logic [1:0]  radix;
    logic [63:0] accum;
    bit          failed;
    int unsigned seen;
    logic [63:0] value_q[$];
    bit          ok_q[$];
    int          errors;

    function void restart();
      phase  = AT_START;
      radix  = RADIX_DEC;
      accum  = '0;
      failed = 1'b0;
      seen   = 0;
    endfunction

    function logic [4:0] radix_base();
      case (radix)
        RADIX_BIN: return 5'd2;
        RADIX_OCT: return 5'd8;
        RADIX_HEX: return 5'd16;
        default:   return 5'd10;
      endcase
    endfunction

    function logic [4:0] digit_of(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
      if (c >= CH_LC_A && c <= CH_LC_F) return 5'(c - CH_LC_A + 8'd10);
      if (c >= CH_UC_A && c <= CH_UC_F) return 5'(c - CH_UC_A + 8'd10);
      return 5'd31;
    endfunction

    function void take_digit(logic [7:0] c);
      logic [4:0] d;
      if (failed || c == CH_UNDER) return;
      d = digit_of(c);
      if (d >= radix_base()) failed = 1'b1;
      else accum = accum * radix_base() + d;
    endfunction

    // a '0' at the digit start may open a prefix
    function void take_head(logic [7:0] c);
      if (c == CH_ZERO) begin
        phase = AFTER_ZERO;
      end else begin
        phase = IN_DIGITS;
        take_digit(c);
      end
    endfunction

    function void note_request(logic [7:0] c, bit fin);
      case (phase)
        AT_START: begin
          if (c == CH_PLUS && !fin) phase = AFTER_SIGN;
          else take_head(c);
        end
        AFTER_SIGN: take_head(c);
        AFTER_ZERO: begin
          // prefix only counts when the literal is longer than two characters
          if ((c == CH_LC_B || c == CH_LC_O || c == CH_LC_X) && (!fin || seen >= 2))
            radix = (c == CH_LC_B) ? RADIX_BIN : (c == CH_LC_O) ? RADIX_OCT : RADIX_HEX;
          else
            take_digit(c);
          phase = IN_DIGITS;
        end
        default: take_digit(c);
      endcase
      if (seen < 3) seen++;
      if (fin) begin
        value_q.push_back(accum);
        ok_q.push_back(!failed);
        restart();
      end
    endfunction

    function void check_result(logic [63:0] v, logic ok);
      logic [63:0] exp_v;
      bit          exp_ok;
      if (value_q.size() == 0) begin
        $display("%0t: unexpected result value=%h ok=%b", $time, v, ok);
        errors++;
        return;
      end
      exp_v  = value_q.pop_front();
      exp_ok = ok_q.pop_front();
      if (v !== exp_v) begin
        $display("%0t: value expected %h actual %h", $time, exp_v, v);
        errors++;
      end
      if (ok !== exp_ok) begin
        $display("%0t: ok expected %b actual %b", $time, exp_ok, ok);
        errors++;
      end
    endfunction

    function int pending();
      return value_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic [7:0]  in_ch;
  logic        in_last;
  logic        in_push;
  logic        in_full;
  logic [63:0] out_value;
  logic        out_ok;
  logic        out_empty;
  logic        out_pop;

  literal_scoreboard sb = new;
  int unsigned       items_sent;
  bit                calm;
  bit                hold_req;
  bit                hold_done;
  bit                drain_done;

  integer_literal_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .in_last   (in_last),
    .in_push   (in_push),
    .in_full   (in_full),
    .out_value (out_value),
    .out_ok    (out_ok),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) sb.note_request(in_ch, in_last);
      if (out_pop && !out_empty) sb.check_result(out_value, out_ok);
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 150;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic push_char(input logic [7:0] c, input bit fin);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_ch   <= c;
    in_last <= fin;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  task automatic send_bytes(input char_q_t lit);
    int i;
    for (i = 0; i < lit.size(); i++) push_char(lit[i], i == lit.size() - 1);
  endtask

  task automatic send_text(input string s);
    char_q_t lit;
    int      i;
    for (i = 0; i < s.len(); i++) lit.push_back(s[i]);
    send_bytes(lit);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic make_literal(output char_q_t lit);
    int         kind;
    int         ndig;
    int         i;
    int         pos;
    logic [1:0] rad;
    logic [4:0] d;
    logic [4:0] base;
    lit  = {};
    kind = $urandom_range(0, 19);
    if (kind <= 1) begin
      // raw noise bytes
      repeat ($urandom_range(1, 4)) lit.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) lit.push_back(CH_PLUS);
    rad = (kind == 4) ? RADIX_HEX : 2'($urandom_range(0, 3));
    if (rad != RADIX_DEC) begin
      lit.push_back(CH_ZERO);
      lit.push_back(rad == RADIX_BIN ? CH_LC_B : rad == RADIX_OCT ? CH_LC_O : CH_LC_X);
    end
    case (rad)
      RADIX_BIN: base = 5'd2;
      RADIX_OCT: base = 5'd8;
      RADIX_HEX: base = 5'd16;
      default:   base = 5'd10;
    endcase
    if (kind == 4) ndig = $urandom_range(16, 17);
    else if ($urandom_range(0, 7) == 0) ndig = $urandom_range(12, 24);
    else ndig = $urandom_range(rad == RADIX_DEC ? 1 : 0, 6);
    for (i = 0; i < ndig; i++) begin
      if (kind != 4 && $urandom_range(0, 5) == 0) begin
        lit.push_back(CH_UNDER);
      end else begin
        d = (kind == 4) ? 5'd15 : 5'($urandom_range(0, base - 1));
        if (d < 10) lit.push_back(CH_ZERO + 8'(d));
        else lit.push_back(($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(d - 10));
      end
    end
    if (lit.size() == 0) lit.push_back(CH_ZERO);
    if (kind <= 3) begin
      // corrupt one character
      pos = $urandom_range(0, lit.size() - 1);
      lit[pos] = 8'($urandom_range(0, 255));
    end
  endtask

  initial begin
    char_q_t lit;
    in_ch   = '0;
    in_last = 1'b0;
    in_push = 1'b0;
    rst_n   = 1'b0;
    sb.restart();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("+");
    send_text("0x");
    send_text("+0x");
    send_text(" ");
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    send_text("0o8");
    send_text("1_z9");
    send_text("+0b_");
    send_text("9");
    send_text("0xaF");

    while (items_sent < 1130) begin
      if (!hold_done && items_sent >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= 650) begin
        drain_done = 1'b1;
        wait_for_results();
      end
      if (items_sent >= 980) calm = 1'b1;
      make_literal(lit);
      send_bytes(lit);
    end
    @(negedge clk);
    in_push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
